>>> sv/fvcw_pkg.sv
// Shared types, wheel table and arithmetic helpers for the flow color wheel.
package fvcw_pkg;

  localparam int WHEEL_LAST = 53;

  typedef struct packed {
    logic signed [15:0] flow_x;
    logic signed [15:0] flow_y;
    logic               flow_ok;
  } flow_t;

  typedef struct packed {
    logic [7:0] blue;
    logic [7:0] green;
    logic [7:0] red;
  } pixel_t;

  // Word after the front classification.
  typedef struct packed {
    logic signed [15:0] x;
    logic signed [15:0] y;
    logic               ok;
    logic               xneg;
    logic               xzero;
    logic               yzero;
    logic               ypos;
  } cls_t;

  // Everything one word carries through the back pipeline.
  typedef struct packed {
    logic               ok;
    logic               xneg;
    logic               xzero;
    logic               yzero;
    logic               ypos;
    logic               in_circle;
    logic [31:0]        xx;
    logic [31:0]        yy;
    logic [31:0]        mm;
    logic [31:0]        s;
    logic signed [33:0] px;
    logic signed [33:0] py;
    logic [31:0]        z;
    logic [32:0]        rem;
    logic [31:0]        root;
    logic [16:0]        drem;
    logic [16:0]        q;
    logic [5:0]         k0;
    logic [15:0]        f;
    logic [23:0]        cr;
    logic [23:0]        cg;
    logic [23:0]        cb;
    pixel_t             pix;
  } stage_t;

  // Wheel entry as {red, green, blue}.
  function automatic logic [23:0] wheel_rgb(input logic [5:0] k);
    logic [23:0] w;
    case (k)
      6'd0:  w = {8'd255, 8'd0,   8'd0};
      6'd1:  w = {8'd255, 8'd17,  8'd0};
      6'd2:  w = {8'd255, 8'd34,  8'd0};
      6'd3:  w = {8'd255, 8'd51,  8'd0};
      6'd4:  w = {8'd255, 8'd68,  8'd0};
      6'd5:  w = {8'd255, 8'd85,  8'd0};
      6'd6:  w = {8'd255, 8'd102, 8'd0};
      6'd7:  w = {8'd255, 8'd119, 8'd0};
      6'd8:  w = {8'd255, 8'd136, 8'd0};
      6'd9:  w = {8'd255, 8'd153, 8'd0};
      6'd10: w = {8'd255, 8'd170, 8'd0};
      6'd11: w = {8'd255, 8'd187, 8'd0};
      6'd12: w = {8'd255, 8'd204, 8'd0};
      6'd13: w = {8'd255, 8'd221, 8'd0};
      6'd14: w = {8'd255, 8'd238, 8'd0};
      6'd15: w = {8'd255, 8'd255, 8'd0};
      6'd16: w = {8'd213, 8'd255, 8'd0};
      6'd17: w = {8'd170, 8'd255, 8'd0};
      6'd18: w = {8'd128, 8'd255, 8'd0};
      6'd19: w = {8'd85,  8'd255, 8'd0};
      6'd20: w = {8'd43,  8'd255, 8'd0};
      6'd21: w = {8'd0,   8'd255, 8'd0};
      6'd22: w = {8'd0,   8'd255, 8'd63};
      6'd23: w = {8'd0,   8'd255, 8'd127};
      6'd24: w = {8'd0,   8'd255, 8'd191};
      6'd25: w = {8'd0,   8'd255, 8'd255};
      6'd26: w = {8'd0,   8'd232, 8'd255};
      6'd27: w = {8'd0,   8'd209, 8'd255};
      6'd28: w = {8'd0,   8'd186, 8'd255};
      6'd29: w = {8'd0,   8'd163, 8'd255};
      6'd30: w = {8'd0,   8'd140, 8'd255};
      6'd31: w = {8'd0,   8'd116, 8'd255};
      6'd32: w = {8'd0,   8'd93,  8'd255};
      6'd33: w = {8'd0,   8'd70,  8'd255};
      6'd34: w = {8'd0,   8'd47,  8'd255};
      6'd35: w = {8'd0,   8'd24,  8'd255};
      6'd36: w = {8'd0,   8'd0,   8'd255};
      6'd37: w = {8'd19,  8'd0,   8'd255};
      6'd38: w = {8'd39,  8'd0,   8'd255};
      6'd39: w = {8'd58,  8'd0,   8'd255};
      6'd40: w = {8'd78,  8'd0,   8'd255};
      6'd41: w = {8'd98,  8'd0,   8'd255};
      6'd42: w = {8'd117, 8'd0,   8'd255};
      6'd43: w = {8'd137, 8'd0,   8'd255};
      6'd44: w = {8'd156, 8'd0,   8'd255};
      6'd45: w = {8'd176, 8'd0,   8'd255};
      6'd46: w = {8'd196, 8'd0,   8'd255};
      6'd47: w = {8'd215, 8'd0,   8'd255};
      6'd48: w = {8'd235, 8'd0,   8'd255};
      6'd49: w = {8'd255, 8'd0,   8'd255};
      6'd50: w = {8'd255, 8'd0,   8'd213};
      6'd51: w = {8'd255, 8'd0,   8'd170};
      6'd52: w = {8'd255, 8'd0,   8'd128};
      6'd53: w = {8'd255, 8'd0,   8'd85};
      6'd54: w = {8'd255, 8'd0,   8'd43};
      default: w = 24'd0;
    endcase
    return w;
  endfunction

  // atan(2^-i) as a fraction of a full turn, 2^32 per turn.
  function automatic logic [31:0] atan_turn(input int i);
    logic [31:0] a;
    case (i)
      0:  a = 32'd536870912;
      1:  a = 32'd316933406;
      2:  a = 32'd167458907;
      3:  a = 32'd85004756;
      4:  a = 32'd42667331;
      5:  a = 32'd21354465;
      6:  a = 32'd10679838;
      7:  a = 32'd5340245;
      8:  a = 32'd2670163;
      9:  a = 32'd1335086;
      10: a = 32'd667544;
      11: a = 32'd333772;
      12: a = 32'd166886;
      13: a = 32'd83443;
      14: a = 32'd41722;
      15: a = 32'd20861;
      16: a = 32'd10430;
      17: a = 32'd5215;
      18: a = 32'd2608;
      19: a = 32'd1304;
      20: a = 32'd652;
      21: a = 32'd326;
      22: a = 32'd163;
      23: a = 32'd81;
      default: a = 32'd0;
    endcase
    return a;
  endfunction

  // Linear blend of two wheel entries, 255-scale in Q16.
  function automatic logic [23:0] mix(input logic [15:0] f, input logic [7:0] a,
                                      input logic [7:0] b);
    logic [16:0] g;
    logic [24:0] sum;
    g   = 17'd65536 - {1'b0, f};
    sum = (25'(g) * 25'(a)) + (25'(f) * 25'(b));
    return sum[23:0];
  endfunction

  // Final channel value from the blended color and the radius.
  function automatic logic [7:0] shade(input logic [23:0] c, input logic [16:0] r,
                                       input logic in_circle, input logic ok);
    logic [23:0] d;
    logic [40:0] t;
    logic [39:0] v;
    logic [25:0] o;
    d = 24'd16711680 - c;
    t = 41'(d) * 41'(r);
    v = 40'hFF_0000_0000 - t[39:0];
    o = 26'(c) * 26'd3;
    if (!ok) begin
      return 8'd0;
    end else if (in_circle) begin
      return v[39:32];
    end else begin
      return o[25:18];
    end
  endfunction

endpackage

>>> sv/fvcw_queue.sv
// Two-entry register queue used between pipeline parts and at the output.
module fvcw_queue #(
  parameter int W = 8
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         push,
  input  logic [W-1:0] wdata,
  output logic         full,
  input  logic         pop,
  output logic [W-1:0] rdata,
  output logic         empty
);

  logic [W-1:0] mem [2];
  logic         wp;
  logic         rp;
  logic [1:0]   cnt;
  logic         do_push;
  logic         do_pop;

  assign full    = (cnt == 2'd2);
  assign empty   = (cnt == 2'd0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = mem[rp];

  always_ff @(posedge clk) begin
    if (rst) begin
      wp  <= 1'b0;
      rp  <= 1'b0;
      cnt <= 2'd0;
    end else begin
      if (do_push) begin
        wp <= ~wp;
      end
      if (do_pop) begin
        rp <= ~rp;
      end
      cnt <= cnt + 2'(do_push) - 2'(do_pop);
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wp] <= wdata;
    end
  end

endmodule

>>> sv/fvcw_front.sv
// Front part: takes flow words and flags the sign and axis cases.
module fvcw_front (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  input  fvcw_pkg::flow_t    flow,
  output logic               full,
  output logic               cls_vld,
  output fvcw_pkg::cls_t     cls,
  input  logic               down_full
);

  fvcw_pkg::cls_t cls_next;

  assign full = cls_vld && down_full;

  always_comb begin
    cls_next.x     = flow.flow_x;
    cls_next.y     = flow.flow_y;
    cls_next.ok    = flow.flow_ok;
    cls_next.xneg  = flow.flow_x[15];
    cls_next.xzero = (flow.flow_x == 16'sd0);
    cls_next.yzero = (flow.flow_y == 16'sd0);
    cls_next.ypos  = !flow.flow_y[15] && (flow.flow_y != 16'sd0);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cls_vld <= 1'b0;
    end else if (!full) begin
      cls_vld <= push;
    end
  end

  always_ff @(posedge clk) begin
    if (!full && push) begin
      cls <= cls_next;
    end
  end

endmodule

>>> sv/fvcw_back.sv
// Back part: radius, phase and wheel blend as one stallable pipeline.
module fvcw_back #(
  parameter int CORDIC_STEPS = 16
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              adv,
  input  logic              in_vld,
  input  fvcw_pkg::cls_t    cls,
  input  logic [15:0]       max_motion,
  output logic              out_vld,
  output fvcw_pkg::pixel_t  pix
);

  localparam int ST_SUM = 1;
  localparam int ST_SQ0 = 2;
  localparam int NSQ    = 32;
  localparam int ST_DV0 = ST_SQ0 + NSQ;
  localparam int NDV    = 17;
  localparam int ST_PH  = ST_DV0 + NDV;
  localparam int ST_MIX = ST_PH + 1;
  localparam int ST_OUT = ST_MIX + 1;
  localparam int NS     = ST_OUT + 1;

  logic [15:0]      m;
  logic [NS-1:0]    vld;
  fvcw_pkg::stage_t pipe [NS];
  fvcw_pkg::stage_t nxt  [NS];

  assign m       = (max_motion == 16'd0) ? 16'd1 : max_motion;
  assign out_vld = vld[NS-1];
  assign pix     = pipe[NS-1].pix;

  for (genvar k = 0; k < NS; k++) begin : g_st
    localparam int CI = (k >= 1 && k - 1 < 24) ? k - 1 : 23;
    localparam int QP = (k >= ST_SQ0 && k < ST_DV0) ? ST_SQ0 + 31 - k : 0;
    localparam int DB = (k >= ST_DV0 && k < ST_PH) ? ST_DV0 + 16 - k : 0;

    if (k == 0) begin : g_in
      always_comb begin
        logic signed [31:0] sx;
        logic signed [31:0] sy;
        logic signed [33:0] ex;
        logic signed [33:0] ey;
        sx = cls.x * cls.x;
        sy = cls.y * cls.y;
        ex = {{4{cls.x[15]}}, cls.x, 14'b0};
        ey = {{4{cls.y[15]}}, cls.y, 14'b0};
        nxt[0]        = '0;
        nxt[0].ok     = cls.ok;
        nxt[0].xneg   = cls.xneg;
        nxt[0].xzero  = cls.xzero;
        nxt[0].yzero  = cls.yzero;
        nxt[0].ypos   = cls.ypos;
        nxt[0].xx     = unsigned'(sx);
        nxt[0].yy     = unsigned'(sy);
        nxt[0].mm     = m * m;
        nxt[0].px     = cls.xneg ? -ex : ex;
        nxt[0].py     = cls.xneg ? -ey : ey;
        nxt[0].z      = cls.xneg ? 32'h8000_0000 : 32'h0;
      end
    end else begin : g_op
      always_comb begin
        logic [63:0] v;
        logic [34:0] rn;
        logic [34:0] trial;
        logic [16:0] rin;
        logic [16:0] t;
        logic [31:0] zs;
        logic [37:0] fk;
        logic [23:0] w0;
        logic [23:0] w1;
        nxt[k] = pipe[k-1];
        v      = {pipe[k-1].s, 32'b0};
        rn     = {pipe[k-1].rem, v[2*QP+1 -: 2]};
        trial  = {1'b0, pipe[k-1].root, 2'b01};
        rin    = (k == ST_DV0) ? {2'b0, pipe[k-1].root[31:17]} : pipe[k-1].drem;
        t      = {rin[15:0], pipe[k-1].root[DB]};
        if (pipe[k-1].yzero) begin
          zs = pipe[k-1].xneg ? 32'h8000_0000 : 32'h0;
        end else if (pipe[k-1].xzero) begin
          zs = pipe[k-1].ypos ? 32'h4000_0000 : 32'hC000_0000;
        end else begin
          zs = pipe[k-1].z;
        end
        fk = 38'(zs) * 38'd54;
        w0 = fvcw_pkg::wheel_rgb(pipe[k-1].k0);
        w1 = fvcw_pkg::wheel_rgb(pipe[k-1].k0 + 6'd1);

        // Vectoring rotation toward the x axis.
        if (k - 1 < CORDIC_STEPS) begin
          if (pipe[k-1].py > 34'sd0) begin
            nxt[k].px = pipe[k-1].px + (pipe[k-1].py >>> CI);
            nxt[k].py = pipe[k-1].py - (pipe[k-1].px >>> CI);
            nxt[k].z  = pipe[k-1].z + fvcw_pkg::atan_turn(CI);
          end else begin
            nxt[k].px = pipe[k-1].px - (pipe[k-1].py >>> CI);
            nxt[k].py = pipe[k-1].py + (pipe[k-1].px >>> CI);
            nxt[k].z  = pipe[k-1].z - fvcw_pkg::atan_turn(CI);
          end
        end

        if (k == ST_SUM) begin
          nxt[k].s         = pipe[k-1].xx + pipe[k-1].yy;
          nxt[k].in_circle = (pipe[k-1].xx + pipe[k-1].yy) <= pipe[k-1].mm;
        end

        // One root bit per stage.
        if (k >= ST_SQ0 && k < ST_DV0) begin
          if (rn >= trial) begin
            nxt[k].rem  = 33'(rn - trial);
            nxt[k].root = {pipe[k-1].root[30:0], 1'b1};
          end else begin
            nxt[k].rem  = rn[32:0];
            nxt[k].root = {pipe[k-1].root[30:0], 1'b0};
          end
        end

        // One quotient bit per stage.
        if (k >= ST_DV0 && k < ST_PH) begin
          if (t >= {1'b0, m}) begin
            nxt[k].drem = t - {1'b0, m};
            nxt[k].q    = {pipe[k-1].q[15:0], 1'b1};
          end else begin
            nxt[k].drem = t;
            nxt[k].q    = {pipe[k-1].q[15:0], 1'b0};
          end
        end

        if (k == ST_PH) begin
          nxt[k].k0 = (fk[37:32] > 6'(fvcw_pkg::WHEEL_LAST)) ?
                      6'(fvcw_pkg::WHEEL_LAST) : fk[37:32];
          nxt[k].f  = fk[31:16];
        end

        if (k == ST_MIX) begin
          nxt[k].cr = fvcw_pkg::mix(pipe[k-1].f, w0[23:16], w1[23:16]);
          nxt[k].cg = fvcw_pkg::mix(pipe[k-1].f, w0[15:8], w1[15:8]);
          nxt[k].cb = fvcw_pkg::mix(pipe[k-1].f, w0[7:0], w1[7:0]);
        end

        if (k == ST_OUT) begin
          nxt[k].pix.red   = fvcw_pkg::shade(pipe[k-1].cr, pipe[k-1].q,
                                             pipe[k-1].in_circle, pipe[k-1].ok);
          nxt[k].pix.green = fvcw_pkg::shade(pipe[k-1].cg, pipe[k-1].q,
                                             pipe[k-1].in_circle, pipe[k-1].ok);
          nxt[k].pix.blue  = fvcw_pkg::shade(pipe[k-1].cb, pipe[k-1].q,
                                             pipe[k-1].in_circle, pipe[k-1].ok);
        end
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[k] <= 1'b0;
      end else if (adv) begin
        vld[k] <= (k == 0) ? in_vld : vld[(k == 0) ? 0 : k - 1];
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        pipe[k] <= nxt[k];
      end
    end
  end

endmodule

>>> sv/flow_vector_color_wheel.sv
// Top level of the optical-flow color wheel: front, queue, pipeline, output queue.
// Usage: one flow word (flow_x, flow_y signed Q8.8 and flow_ok) goes in per pixel
// through a queue-style port: it is taken at a clock edge with push high and full low.
// Each word yields exactly one BGR pixel word on the pix port, shown while empty is
// low and taken at an edge with pop high. Words leave in the order they came in.
// From the accepting edge to empty going low for that pixel, a word passes through
// one front register, the decoupling queue, a 54-stage back pipeline (squares,
// sum, 32 root stages, 17 divide stages, phase, blend, shade) and the output
// queue. The square root and the divide by max_motion set this depth; the CORDIC phase
// runs alongside the root stages. Throughput is one word per cycle while pops keep up.
// When the receiver stops popping, the output queue fills, the back pipeline holds,
// the middle queue fills and full rises; nothing is dropped. A two-entry queue at
// each boundary lets the front keep taking words while a finished pixel waits.
// Synchronous reset empties every queue and pipeline stage and sets max_motion to
// 10.0 (2560). Write max_motion only while the block is empty and idle; zero acts as
// the smallest step.
module flow_vector_color_wheel #(
  parameter int CORDIC_STEPS = 16
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  fvcw_pkg::flow_t   flow,
  output logic              full,
  input  logic              pop,
  output fvcw_pkg::pixel_t  pix,
  output logic              empty,
  input  logic              cfg_write,
  input  logic [15:0]       cfg_data
);

  logic [15:0]      max_motion;
  logic             cls_vld;
  fvcw_pkg::cls_t   cls;
  logic             mid_full;
  logic             mid_empty;
  fvcw_pkg::cls_t   mid_word;
  logic             adv;
  logic             back_vld;
  fvcw_pkg::pixel_t back_pix;
  logic             out_full;

  // The single configuration register.
  always_ff @(posedge clk) begin
    if (rst) begin
      max_motion <= 16'd2560;
    end else if (cfg_write) begin
      max_motion <= cfg_data;
    end
  end

  fvcw_front u_front (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .flow      (flow),
    .full      (full),
    .cls_vld   (cls_vld),
    .cls       (cls),
    .down_full (mid_full)
  );

  fvcw_queue #(.W($bits(fvcw_pkg::cls_t))) u_mid (
    .clk   (clk),
    .rst   (rst),
    .push  (cls_vld),
    .wdata (cls),
    .full  (mid_full),
    .pop   (adv),
    .rdata (mid_word),
    .empty (mid_empty)
  );

  // The whole back pipeline moves unless its last word cannot enter the output queue.
  assign adv = !(back_vld && out_full);

  fvcw_back #(.CORDIC_STEPS(CORDIC_STEPS)) u_back (
    .clk        (clk),
    .rst        (rst),
    .adv        (adv),
    .in_vld     (!mid_empty),
    .cls        (mid_word),
    .max_motion (max_motion),
    .out_vld    (back_vld),
    .pix        (back_pix)
  );

  fvcw_queue #(.W($bits(fvcw_pkg::pixel_t))) u_out (
    .clk   (clk),
    .rst   (rst),
    .push  (back_vld),
    .wdata (back_pix),
    .full  (out_full),
    .pop   (pop),
    .rdata (pix),
    .empty (empty)
  );

endmodule

>>> dv/flow_vector_color_wheel_tb.sv
// Self-checking testbench for the optical-flow color wheel block.
`timescale 1ns / 100ps

module flow_vector_color_wheel_tb;

  localparam int WATCHDOG_LIMIT = 20000;
  localparam int DRAIN_CYCLES   = 80;
  localparam int RANDOM_WORDS   = 1300;

  logic             clk;
  logic             rst;
  logic             push;
  fvcw_pkg::flow_t  flow;
  logic             full;
  logic             pop;
  fvcw_pkg::pixel_t pix;
  logic             empty;
  logic             cfg_write;
  logic [15:0]      cfg_data;

  // Copy of max_motion that the color predictor uses.
  logic [15:0] motion_scale;
  // Pixels predicted but not yet popped, oldest first.
  fvcw_pkg::pixel_t pending_pixels[$];
  int          mismatch_count;
  int          idle_cycles;
  // Percent of cycles in which each side idles.
  int          push_idle_pct;
  int          pop_idle_pct;
  // Set while the long receiver hold-off is running.
  logic        pop_hold;

  flow_vector_color_wheel u_dut (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .flow     (flow),
    .full     (full),
    .pop      (pop),
    .pix      (pix),
    .empty    (empty),
    .cfg_write(cfg_write),
    .cfg_data (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Wheel entries {red, green, blue}, written out again from the color coding scheme.
  function automatic logic [23:0] hue_entry(input int k);
    logic [23:0] ramp[55];
    ramp = '{
      24'hFF0000, 24'hFF1100, 24'hFF2200, 24'hFF3300, 24'hFF4400, 24'hFF5500,
      24'hFF6600, 24'hFF7700, 24'hFF8800, 24'hFF9900, 24'hFFAA00, 24'hFFBB00,
      24'hFFCC00, 24'hFFDD00, 24'hFFEE00, 24'hFFFF00, 24'hD5FF00, 24'hAAFF00,
      24'h80FF00, 24'h55FF00, 24'h2BFF00, 24'h00FF00, 24'h00FF3F, 24'h00FF7F,
      24'h00FFBF, 24'h00FFFF, 24'h00E8FF, 24'h00D1FF, 24'h00BAFF, 24'h00A3FF,
      24'h008CFF, 24'h0074FF, 24'h005DFF, 24'h0046FF, 24'h002FFF, 24'h0018FF,
      24'h0000FF, 24'h1300FF, 24'h2700FF, 24'h3A00FF, 24'h4E00FF, 24'h6200FF,
      24'h7500FF, 24'h8900FF, 24'h9C00FF, 24'hB000FF, 24'hC400FF, 24'hD700FF,
      24'hEB00FF, 24'hFF00FF, 24'hFF00D5, 24'hFF00AA, 24'hFF0080, 24'hFF0055,
      24'hFF002B};
    return ramp[k];
  endfunction

  function automatic longint unsigned int_sqrt(input longint unsigned v);
    longint unsigned root;
    longint unsigned bitv;
    root = 0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (v >= root + bitv) begin
        v    = v - (root + bitv);
        root = (root >> 1) + bitv;
      end else begin
        root = root >> 1;
      end
      bitv = bitv >> 2;
    end
    return root;
  endfunction

  // Arctangent turn constants for the vectoring rotation.
  function automatic logic [31:0] turn_step(input int i);
    logic [31:0] tab[16];
    tab = '{32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756,
            32'd42667331, 32'd21354465, 32'd10679838, 32'd5340245,
            32'd2670163, 32'd1335086, 32'd667544, 32'd333772,
            32'd166886, 32'd83443, 32'd41722, 32'd20861};
    return tab[i];
  endfunction

  // Angle of the vector as a 32-bit fraction of a full turn.
  function automatic logic [31:0] flow_angle(input longint x, input longint y);
    longint px, py, nx, ny;
    logic [31:0] z;
    if (y == 0) return (x < 0) ? 32'h8000_0000 : 32'h0;
    if (x == 0) return (y > 0) ? 32'h4000_0000 : 32'hC000_0000;
    if (x < 0) begin
      px = -x * 16384; py = -y * 16384; z = 32'h8000_0000;
    end else begin
      px = x * 16384;  py = y * 16384;  z = 32'h0;
    end
    for (int i = 0; i < 16; i++) begin
      // Arithmetic shift right of a signed value floors, as required.
      if (py > 0) begin
        nx = px + (py >>> i); ny = py - (px >>> i); z = z + turn_step(i);
      end else begin
        nx = px - (py >>> i); ny = py + (px >>> i); z = z - turn_step(i);
      end
      px = nx; py = ny;
    end
    return z;
  endfunction

  function automatic fvcw_pkg::pixel_t predict_color(input fvcw_pkg::flow_t w,
                                                     input logic [15:0] scale);
    fvcw_pkg::pixel_t p;
    longint          x, y;
    longint unsigned m, s, r16, fk, f, c, t, v;
    int              k0, k1;
    logic            in_circle;
    logic [23:0]     e0, e1;
    logic [7:0]      ch[3];
    if (!w.flow_ok) return '0;
    x = longint'(w.flow_x);
    y = longint'(w.flow_y);
    m = (scale == 0) ? 1 : scale;
    s = x * x + y * y;
    in_circle = (s <= m * m);
    r16 = 0;
    if (in_circle) begin
      r16 = int_sqrt(s << 32) / m;
      if (r16 > 65536) r16 = 65536;
    end
    fk = longint'(flow_angle(x, y)) * 54;
    k0 = int'(fk >> 32);
    if (k0 > 53) k0 = 53;
    k1 = (k0 + 1) % 55;
    f  = (fk >> 16) & 64'hFFFF;
    e0 = hue_entry(k0);
    e1 = hue_entry(k1);
    for (int b = 0; b < 3; b++) begin
      c = (65536 - f) * e0[23 - 8 * b -: 8] + f * e1[23 - 8 * b -: 8];
      if (in_circle) begin
        t = (255 * 65536 - c) * r16;
        v = ((64'd255 << 32) - t) >> 32;
      end else begin
        v = (3 * c) >> 18;
      end
      ch[b] = v[7:0];
    end
    p.red = ch[0]; p.green = ch[1]; p.blue = ch[2];
    return p;
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("MISMATCH %s: got %0d expected %0d at %0t", what, got, want, $time);
    mismatch_count++;
  endtask

  // Directed rows; a known pixel is typed in only where it is obvious.
  typedef struct {
    fvcw_pkg::flow_t  w;
    logic             known;
    fvcw_pkg::pixel_t want;
  } color_row_t;

  color_row_t directed_rows[$];

  task automatic add_row(input int x, input int y, input logic ok, input logic known,
                         input fvcw_pkg::pixel_t want);
    color_row_t r;
    r.w.flow_x  = 16'(x);
    r.w.flow_y  = 16'(y);
    r.w.flow_ok = ok;
    r.known     = known;
    r.want      = want;
    directed_rows.push_back(r);
  endtask

  // Offer one word and wait for it to be taken; the predictor runs on acceptance.
  // Push stays high afterwards so that words can follow back to back.
  task automatic send_flow(input fvcw_pkg::flow_t w);
    if ($urandom_range(99) < push_idle_pct) begin
      push <= 1'b0;
      @(posedge clk);
      while ($urandom_range(99) < push_idle_pct) @(posedge clk);
    end
    push <= 1'b1;
    flow <= w;
    @(posedge clk);
    while (full) @(posedge clk);
  endtask

  // Accepted words go into the expectation queue here, sampled at the clock edge.
  always @(posedge clk) begin
    if (!rst && push && !full)
      pending_pixels.push_back(predict_color(flow, motion_scale));
  end

  // Receiver: random pop, plus the long hold-off when asked.
  always @(posedge clk) begin
    if (rst) begin
      pop <= 1'b0;
    end else begin
      pop <= !pop_hold && ($urandom_range(99) >= pop_idle_pct);
    end
  end

  // Output checker and the watchdog on cycles with no handshake.
  always @(posedge clk) begin
    fvcw_pkg::pixel_t want;
    if (!rst) begin
      if (pop && !empty) begin
        if (pending_pixels.size() == 0) begin
          report_mismatch("unexpected pixel", pix, 0);
        end else begin
          want = pending_pixels.pop_front();
          if (pix.blue != want.blue) report_mismatch("blue", pix.blue, want.blue);
          if (pix.green != want.green) report_mismatch("green", pix.green, want.green);
          if (pix.red != want.red) report_mismatch("red", pix.red, want.red);
        end
      end
      if ((pop && !empty) || (push && !full)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("flow_vector_color_wheel verification failed");
        $finish;
      end
    end
  end

  task automatic wait_drained();
    push <= 1'b0;
    while (pending_pixels.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Register write, only while the block is drained.
  task automatic set_scale(input logic [15:0] value);
    cfg_write <= 1'b1;
    cfg_data  <= value;
    @(posedge clk);
    cfg_write <= 1'b0;
    motion_scale = value;
  endtask

  function automatic fvcw_pkg::flow_t random_flow();
    fvcw_pkg::flow_t w;
    int    mode;
    mode = $urandom_range(9);
    w.flow_ok = ($urandom_range(9) != 0);
    if (mode < 5) begin
      // Half of the words lie near the current radius so both inside and outside show up.
      w.flow_x = 16'($signed($urandom_range(2 * motion_scale + 2)) - motion_scale - 1);
      w.flow_y = 16'($signed($urandom_range(2 * motion_scale + 2)) - motion_scale - 1);
    end else if (mode == 5) begin
      w.flow_x = 16'($signed($urandom_range(8)) - 4);
      w.flow_y = 16'($urandom);
    end else begin
      w.flow_x = 16'($urandom);
      w.flow_y = 16'($urandom);
    end
    return w;
  endfunction

  task automatic random_phase(input int words);
    for (int i = 0; i < words; i++) send_flow(random_flow());
  endtask

  initial begin
    logic [15:0] scales[5];
    rst = 1'b1;
    push = 1'b0;
    flow = '0;
    cfg_write = 1'b0;
    cfg_data = 16'd0;
    pop_hold = 1'b0;
    mismatch_count = 0;
    idle_cycles = 0;
    push_idle_pct = 0;
    pop_idle_pct = 0;
    motion_scale = 16'd2560;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed table: invalid vectors give black, the zero vector gives white,
    // axis directions, field extremes and the outside scale by three quarters.
    add_row(0, 0, 1'b0, 1'b1, '{8'd0, 8'd0, 8'd0});
    add_row(-32768, 32767, 1'b0, 1'b1, '{8'd0, 8'd0, 8'd0});
    add_row(0, 0, 1'b1, 1'b1, '{8'd255, 8'd255, 8'd255});
    // Pure +x far outside: red wheel entry times 3/4 gives red 191.
    add_row(32767, 0, 1'b1, 1'b1, '{8'd0, 8'd0, 8'd191});
    // Exactly on the radius along +x: full red.
    add_row(2560, 0, 1'b1, 1'b1, '{8'd0, 8'd0, 8'd255});
    add_row(2561, 0, 1'b1, 1'b0, '0);
    add_row(-32768, 0, 1'b1, 1'b0, '0);
    add_row(0, 32767, 1'b1, 1'b0, '0);
    add_row(0, -32768, 1'b1, 1'b0, '0);
    add_row(-32768, -32768, 1'b1, 1'b0, '0);
    add_row(32767, 32767, 1'b1, 1'b0, '0);
    add_row(32767, -32768, 1'b1, 1'b0, '0);
    add_row(-32768, 32767, 1'b1, 1'b0, '0);
    add_row(1, -1, 1'b1, 1'b0, '0);
    add_row(-1, 1, 1'b1, 1'b0, '0);
    add_row(1280, 1280, 1'b1, 1'b0, '0);
    add_row(-1810, 1810, 1'b1, 1'b0, '0);
    add_row(100, -3, 1'b1, 1'b0, '0);
    add_row(21845, 21846, 1'b0, 1'b1, '{8'd0, 8'd0, 8'd0});
    foreach (directed_rows[i]) begin
      send_flow(directed_rows[i].w);
      if (directed_rows[i].known &&
          predict_color(directed_rows[i].w, motion_scale) != directed_rows[i].want)
        report_mismatch("directed row", i, 0);
    end
    wait_drained();

    // Several scales including the extremes; zero acts as the smallest step.
    scales = '{16'd1, 16'd65535, 16'd0, 16'd300, 16'd2560};
    foreach (scales[j]) begin
      set_scale(scales[j]);
      push_idle_pct = 20; pop_idle_pct = 82;
      random_phase(RANDOM_WORDS / 15);
      push_idle_pct = 82; pop_idle_pct = 20;
      random_phase(RANDOM_WORDS / 15);
      push_idle_pct = 0;  pop_idle_pct = 0;
      random_phase(RANDOM_WORDS / 15);
      wait_drained();
    end

    // Long receiver hold-off while the sender keeps offering: the block must fill.
    fork
      begin
        pop_hold = 1'b1;
        repeat (300) @(posedge clk);
        pop_hold = 1'b0;
      end
      random_phase(200);
    join
    wait_drained();

    if (mismatch_count == 0) begin
      $display("flow_vector_color_wheel verification clean");
    end else begin
      $display("flow_vector_color_wheel verification failed");
    end
    $finish;
  end

endmodule
